FILE: rtl/eeprom_controller_registers_top_defines.svh
// Assertion macros for the EEPROM register block checker.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef EEPROM_CONTROLLER_REGISTERS_TOP_DEFINES_SVH
`define EEPROM_CONTROLLER_REGISTERS_TOP_DEFINES_SVH

// same-cycle implication
`define EECR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define EECR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/eecr_pkg.sv
// Shared types and constants of the EEPROM register block.
// No dependencies.
package eecr_pkg;

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned SEL_W    = 2;
  localparam int unsigned WDATA_W  = 16;
  localparam int unsigned RDATA_W  = 10;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned WINDOW_W = 3;
  localparam int unsigned COUNT_W  = 16;

  typedef logic [FUNC_W-1:0]   func_t;
  typedef logic [SEL_W-1:0]    sel_t;
  typedef logic [WDATA_W-1:0]  wdata_t;
  typedef logic [RDATA_W-1:0]  rdata_t;
  typedef logic [BYTE_W-1:0]   byte_t;
  typedef logic [WINDOW_W-1:0] window_t;
  typedef logic [COUNT_W-1:0]  count_t;

  localparam func_t FN_TICK  = 2'd0;
  localparam func_t FN_WRITE = 2'd1;
  localparam func_t FN_READ  = 2'd2;

  localparam sel_t REG_ADDR = 2'd0;
  localparam sel_t REG_DATA = 2'd1;
  localparam sel_t REG_CTRL = 2'd2;

  localparam int unsigned CTL_READ_BIT   = 0;
  localparam int unsigned CTL_WRITE_BIT  = 1;
  localparam int unsigned CTL_MASTER_BIT = 2;

  localparam count_t WTIME_RESET = 16'd8448;
  localparam byte_t  ERASED      = 8'hFF;

endpackage

FILE: rtl/eecr_intf.sv
// Channel interfaces of the EEPROM register block: request, response, config.
// Depends on eecr_pkg.
interface eecr_req_if;
  logic              valid;
  logic              ready;
  eecr_pkg::func_t   func;
  eecr_pkg::sel_t    reg_sel;
  eecr_pkg::wdata_t  wdata;

  modport source (output valid, func, reg_sel, wdata, input ready);
  modport sink   (input valid, func, reg_sel, wdata, output ready);
endinterface

interface eecr_rsp_if;
  logic              valid;
  logic              ready;
  eecr_pkg::rdata_t  rdata;
  logic              write_busy;

  modport source (output valid, rdata, write_busy, input ready);
  modport sink   (input valid, rdata, write_busy, output ready);
endinterface

interface eecr_cfg_if;
  logic              valid;
  logic              ready;
  eecr_pkg::count_t  data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

FILE: rtl/eecr_mem.sv
// Byte-wide cell array: one synchronous write port, one registered read port.
// Depends on eecr_pkg.
module eecr_mem #(
  parameter int unsigned ADDR_BITS = 10
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [ADDR_BITS-1:0] waddr_i,
  input  eecr_pkg::byte_t      wdata_i,
  input  logic [ADDR_BITS-1:0] raddr_i,
  output eecr_pkg::byte_t      rdata_o
);

  eecr_pkg::byte_t mem_q [2**ADDR_BITS];
  eecr_pkg::byte_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/eecr_ctrl.sv
// Register file, write timer, erase sweep and response register.
// Depends on eecr_pkg and eecr_intf; drives the ports of eecr_mem.
module eecr_ctrl #(
  parameter int unsigned ADDR_BITS     = 10,
  parameter int unsigned ENABLE_WINDOW = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  eecr_req_if.sink             req_i,
  eecr_rsp_if.source           rsp_o,
  eecr_cfg_if.sink             cfg_i,
  output logic                 mem_we_o,
  output logic [ADDR_BITS-1:0] mem_waddr_o,
  output eecr_pkg::byte_t      mem_wdata_o,
  output logic [ADDR_BITS-1:0] mem_raddr_o,
  input  eecr_pkg::byte_t      mem_rdata_i
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_RUN,
    ST_LOAD
  } state_e;

  state_e                  state_q, state_d;
  logic [ADDR_BITS-1:0]    clr_q, clr_d;
  logic [ADDR_BITS-1:0]    addr_q, addr_d;
  eecr_pkg::byte_t         data_q, data_d;
  eecr_pkg::window_t       win_q, win_d;
  eecr_pkg::count_t        busy_q, busy_d;
  eecr_pkg::count_t        wtime_q, wtime_d;
  logic                    rsp_valid_q, rsp_valid_d;
  eecr_pkg::rdata_t        rdata_q, rdata_d;
  logic                    wbusy_q, wbusy_d;

  logic req_acc;
  logic busy;
  logic win_open;

  assign busy     = (busy_q != '0);
  assign win_open = (win_q != '0);
  assign req_acc  = req_i.valid && req_i.ready;

  assign req_i.ready      = (state_q == ST_RUN) && (!rsp_valid_q || rsp_o.ready);
  assign cfg_i.ready      = 1'b1;
  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.rdata      = rdata_q;
  assign rsp_o.write_busy = wbusy_q;
  assign mem_raddr_o      = addr_q;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    addr_d      = addr_q;
    data_d      = data_q;
    win_d       = win_q;
    busy_d      = busy_q;
    wtime_d     = wtime_q;
    rsp_valid_d = rsp_valid_q;
    rdata_d     = rdata_q;
    wbusy_d     = wbusy_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = addr_q;
    mem_wdata_o = data_q;

    if (cfg_i.valid) begin
      wtime_d = cfg_i.data;
    end
    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_q;
        mem_wdata_o = eecr_pkg::ERASED;
        clr_d       = clr_q + 1'b1;
        if (&clr_q) begin
          state_d = ST_RUN;
        end
      end
      ST_LOAD: begin
        data_d  = mem_rdata_i;
        state_d = ST_RUN;
      end
      ST_RUN: begin
        if (req_acc) begin
          rdata_d = '0;
          case (req_i.func)
            eecr_pkg::FN_TICK: begin
              if (win_open) begin
                win_d = win_q - 1'b1;
              end
              if (busy) begin
                busy_d = busy_q - 1'b1;
                if (busy_q == eecr_pkg::count_t'(1)) begin
                  mem_we_o = 1'b1;
                end
              end
            end
            eecr_pkg::FN_WRITE: begin
              case (req_i.reg_sel)
                eecr_pkg::REG_ADDR: begin
                  if (!busy) begin
                    addr_d = req_i.wdata[ADDR_BITS-1:0];
                  end
                end
                eecr_pkg::REG_DATA: begin
                  if (!busy) begin
                    data_d = req_i.wdata[eecr_pkg::BYTE_W-1:0];
                  end
                end
                eecr_pkg::REG_CTRL: begin
                  if (req_i.wdata[eecr_pkg::CTL_READ_BIT] && !busy) begin
                    state_d = ST_LOAD;
                  end
                  if (req_i.wdata[eecr_pkg::CTL_WRITE_BIT] && !busy && win_open) begin
                    busy_d = (wtime_q == '0) ? eecr_pkg::count_t'(1) : wtime_q;
                  end
                  if (req_i.wdata[eecr_pkg::CTL_MASTER_BIT]) begin
                    win_d = eecr_pkg::window_t'(ENABLE_WINDOW);
                  end
                end
                default: begin
                end
              endcase
            end
            eecr_pkg::FN_READ: begin
              case (req_i.reg_sel)
                eecr_pkg::REG_ADDR: rdata_d = eecr_pkg::rdata_t'(addr_q);
                eecr_pkg::REG_DATA: rdata_d = eecr_pkg::rdata_t'(data_q);
                eecr_pkg::REG_CTRL: begin
                  rdata_d[eecr_pkg::CTL_MASTER_BIT] = win_open;
                  rdata_d[eecr_pkg::CTL_WRITE_BIT]  = busy;
                end
                default: rdata_d = '0;
              endcase
            end
            default: begin
            end
          endcase
          rsp_valid_d = 1'b1;
          wbusy_d     = (busy_d != '0);
        end
      end
      default: state_d = ST_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      addr_q      <= '0;
      data_q      <= '0;
      win_q       <= '0;
      busy_q      <= '0;
      wtime_q     <= eecr_pkg::WTIME_RESET;
      rsp_valid_q <= 1'b0;
      rdata_q     <= '0;
      wbusy_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      addr_q      <= addr_d;
      data_q      <= data_d;
      win_q       <= win_d;
      busy_q      <= busy_d;
      wtime_q     <= wtime_d;
      rsp_valid_q <= rsp_valid_d;
      rdata_q     <= rdata_d;
      wbusy_q     <= wbusy_d;
    end
  end

endmodule

FILE: rtl/eeprom_controller_registers_top.sv
// Top level of the EEPROM register block: control logic and cell array.
// Depends on eecr_pkg, eecr_intf, eecr_mem and eecr_ctrl.
//
// Each request (a tick, a register write, a register read or an unused function
// code) gives exactly one response. A control write that sets the read strobe
// while no write is busy passes through a load state that moves the cell array's
// registered read data into the data register. After reset an erase sweep writes
// 0xFF to all 2**ADDR_BITS cells (1024 by default), one per cycle;
// no request is taken during the sweep, while the write-time register can be
// written at any time. The response register lets a new request enter in the
// cycle its response is taken.
module eeprom_controller_registers_top #(
  parameter int unsigned ADDR_BITS     = 10,
  parameter int unsigned ENABLE_WINDOW = 4
) (
  input logic        clk_i,
  input logic        rst_ni,
  eecr_req_if.sink   req_i,
  eecr_rsp_if.source rsp_o,
  eecr_cfg_if.sink   cfg_i
);

  logic                 mem_we;
  logic [ADDR_BITS-1:0] mem_waddr;
  eecr_pkg::byte_t      mem_wdata;
  logic [ADDR_BITS-1:0] mem_raddr;
  eecr_pkg::byte_t      mem_rdata;

  eecr_ctrl #(
    .ADDR_BITS     (ADDR_BITS),
    .ENABLE_WINDOW (ENABLE_WINDOW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .cfg_i       (cfg_i),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  eecr_mem #(
    .ADDR_BITS (ADDR_BITS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

FILE: rtl/eecr_chk.sv
// Port-level checker of the EEPROM register block, bound to the top level.
// Depends on eecr_pkg and eeprom_controller_registers_top_defines.svh.
`include "eeprom_controller_registers_top_defines.svh"

module eecr_chk (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             req_valid_i,
  input logic             req_ready_i,
  input eecr_pkg::func_t  req_func_i,
  input eecr_pkg::sel_t   req_sel_i,
  input logic             rsp_valid_i,
  input logic             rsp_ready_i,
  input eecr_pkg::rdata_t rsp_rdata_i,
  input logic             rsp_busy_i
);

  logic req_acc;
  logic rsp_stall;

  assign req_acc   = req_valid_i && req_ready_i;
  assign rsp_stall = rsp_valid_i && !rsp_ready_i;

  `EECR_ASSERT_NXT(a_rsp_hold, rsp_stall, rsp_valid_i && $stable(rsp_rdata_i) && $stable(rsp_busy_i), "response dropped or changed while stalled")
  `EECR_ASSERT_NXT(a_one_rsp, req_acc, rsp_valid_i, "accepted request gave no response")
  `EECR_ASSERT_NOW(a_no_overrun, rsp_stall, !req_acc, "request taken over a stalled response")
  `EECR_ASSERT_NXT(a_write_zero, req_acc && (req_func_i == eecr_pkg::FN_WRITE), rsp_rdata_i == '0, "register write returned nonzero data")
  `EECR_ASSERT_NXT(a_ctrl_read, req_acc && (req_func_i == eecr_pkg::FN_READ) && (req_sel_i == eecr_pkg::REG_CTRL), (rsp_rdata_i[0] == 1'b0) && (rsp_rdata_i[9:3] == '0) && (rsp_rdata_i[1] == rsp_busy_i), "control read inconsistent")

endmodule

bind eeprom_controller_registers_top eecr_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .req_func_i  (req_i.func),
  .req_sel_i   (req_i.reg_sel),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_rdata_i (rsp_o.rdata),
  .rsp_busy_i  (rsp_o.write_busy)
);

FILE: tb/eecr_checker.sv
// Response checker of the EEPROM register block: watches request, response and
// config channels, predicts each response and compares it field by field.
// Depends on eecr_pkg and the channel interfaces in eecr_intf.
module eecr_checker #(
  parameter int unsigned ADDR_BITS     = 10,
  parameter int unsigned ENABLE_WINDOW = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  eecr_req_if        req_i,
  eecr_rsp_if        rsp_i,
  eecr_cfg_if        cfg_i,
  output int         fail_count_o,
  output int         pending_o,
  output int         checked_o,
  output int         store_count_o,
  output logic       busy_o
);
  import eecr_pkg::*;

  localparam int unsigned CELLS = 2 ** ADDR_BITS;

  typedef struct packed {
    rdata_t rdata;
    logic   busy;
  } eeprom_rsp_t;

  byte_t                 cells [CELLS];
  logic [ADDR_BITS-1:0]  addr_q;
  byte_t                 data_q;
  window_t               window_q;
  count_t                busy_left;
  count_t                wtime_q;
  eeprom_rsp_t           rsp_due [$];

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    fail_count_o++;
    $display("%0t: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  task automatic predict_access(input func_t f, input sel_t s, input wdata_t w,
                                output eeprom_rsp_t e);
    logic was_busy;
    logic win_open;
    was_busy = (busy_left != '0);
    win_open = (window_q != '0);
    e.rdata  = '0;
    case (f)
      FN_TICK: begin
        if (win_open) window_q--;
        if (was_busy) begin
          busy_left--;
          if (busy_left == '0) begin
            cells[addr_q] = data_q;
            store_count_o++;
          end
        end
      end
      FN_WRITE: begin
        case (s)
          REG_ADDR: if (!was_busy) addr_q = w[ADDR_BITS-1:0];
          REG_DATA: if (!was_busy) data_q = w[BYTE_W-1:0];
          REG_CTRL: begin
            if (w[CTL_READ_BIT] && !was_busy) data_q = cells[addr_q];
            if (w[CTL_WRITE_BIT] && !was_busy && win_open) begin
              busy_left = (wtime_q == '0) ? count_t'(1) : wtime_q;
            end
            if (w[CTL_MASTER_BIT]) window_q = window_t'(ENABLE_WINDOW);
          end
          default: ;
        endcase
      end
      FN_READ: begin
        case (s)
          REG_ADDR: e.rdata = rdata_t'(addr_q);
          REG_DATA: e.rdata = rdata_t'(data_q);
          REG_CTRL: begin
            e.rdata[CTL_MASTER_BIT] = win_open;
            e.rdata[CTL_WRITE_BIT]  = was_busy;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    e.busy = (busy_left != '0);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    eeprom_rsp_t e;
    eeprom_rsp_t head;
    if (!rst_ni) begin
      for (int i = 0; i < CELLS; i++) cells[i] = ERASED;
      addr_q        = '0;
      data_q        = '0;
      window_q      = '0;
      busy_left     = '0;
      wtime_q       = WTIME_RESET;
      rsp_due.delete();
      fail_count_o  = 0;
      pending_o     = 0;
      checked_o     = 0;
      store_count_o = 0;
      busy_o        = 1'b0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) wtime_q = cfg_i.data;
      if (rsp_i.valid && rsp_i.ready) begin
        if (rsp_due.size() == 0) begin
          report_mismatch("response with no request", 16'(rsp_i.rdata), '0);
        end else begin
          head = rsp_due.pop_front();
          checked_o++;
          if (rsp_i.rdata !== head.rdata) begin
            report_mismatch("rdata", 16'(rsp_i.rdata), 16'(head.rdata));
          end
          if (rsp_i.write_busy !== head.busy) begin
            report_mismatch("write_busy", 16'(rsp_i.write_busy), 16'(head.busy));
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        predict_access(req_i.func, req_i.reg_sel, req_i.wdata, e);
        rsp_due.push_back(e);
      end
      pending_o = rsp_due.size();
      busy_o    = (busy_left != '0);
    end
  end

endmodule

FILE: tb/tb.sv
// Testbench top of the EEPROM register block: clock, reset, request stimulus,
// response back-pressure, write-time settings and the verdict.
// Depends on eecr_pkg, eecr_intf, eeprom_controller_registers_top and eecr_checker.
module tb;
  import eecr_pkg::*;

  localparam int unsigned ADDR_BITS      = 10;
  localparam int unsigned ENABLE_WINDOW  = 4;
  localparam int          WATCHDOG_LIMIT = 20000;
  localparam int          LONG_HOLD      = 400;

  localparam func_t  FN_NONE  = 2'd3;
  localparam sel_t   REG_NONE = 2'd3;
  localparam wdata_t CTL_RD   = wdata_t'(1) << CTL_READ_BIT;
  localparam wdata_t CTL_WR   = wdata_t'(1) << CTL_WRITE_BIT;
  localparam wdata_t CTL_MS   = wdata_t'(1) << CTL_MASTER_BIT;
  localparam wdata_t CTL_ALL  = CTL_RD | CTL_WR | CTL_MS;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  logic       clk   = 1'b0;
  logic       rst_n = 1'b0;
  idle_mode_e idle_mode = IDLE_NONE;
  int         sent      = 0;
  int         settings  = 0;
  int         hold_asks = 0;

  int   fail_count;
  int   pending;
  int   checked;
  int   stores;
  logic model_busy;

  always #5 clk = ~clk;

  eecr_req_if req_ch ();
  eecr_rsp_if rsp_ch ();
  eecr_cfg_if cfg_ch ();

  eeprom_controller_registers_top #(
    .ADDR_BITS    (ADDR_BITS),
    .ENABLE_WINDOW(ENABLE_WINDOW)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_ch),
    .rsp_o (rsp_ch),
    .cfg_i (cfg_ch)
  );

  eecr_checker #(
    .ADDR_BITS    (ADDR_BITS),
    .ENABLE_WINDOW(ENABLE_WINDOW)
  ) u_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .req_i        (req_ch),
    .rsp_i        (rsp_ch),
    .cfg_i        (cfg_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .store_count_o(stores),
    .busy_o       (model_busy)
  );

  function automatic bit roll(input int unsigned pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic int unsigned send_pct();
    case (idle_mode)
      IDLE_SEND: return 86;
      IDLE_BOTH: return 11;
      default:   return 0;
    endcase
  endfunction

  function automatic int unsigned recv_pct();
    case (idle_mode)
      IDLE_RECV: return 86;
      IDLE_BOTH: return 11;
      default:   return 0;
    endcase
  endfunction

  function automatic wdata_t junk_bits();
    return wdata_t'($urandom) & ~CTL_ALL;
  endfunction

  function automatic wdata_t pick_addr();
    wdata_t pool [8];
    pool = '{16'd0, 16'd1023, 16'd1, 16'd512, 16'd341, 16'd682, 16'd7, 16'd1016};
    if (roll(75)) begin
      return pool[$urandom_range(7)] | (wdata_t'($urandom) & ~wdata_t'(1023));
    end
    return wdata_t'($urandom);
  endfunction

  // response side: random stalls, plus a long hold-off on request
  initial begin : receiver
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= !roll(recv_pct());
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Timeout: %0d cycles with no transfer on any channel", quiet);
    $display("Regression FAIL");
    $finish;
  end

  task automatic send_req(input func_t f, input sel_t s, input wdata_t w);
    while (roll(send_pct())) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.func    <= f;
    req_ch.reg_sel <= s;
    req_ch.wdata   <= w;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
    sent++;
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // tick until the array write in flight has landed
  task automatic drain_busy();
    idle_mode = IDLE_NONE;
    while (model_busy) send_req(FN_TICK, REG_ADDR, wdata_t'($urandom));
  endtask

  task automatic set_wtime(input count_t v);
    drain_busy();
    wait_drained();
    repeat (4) @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    settings++;
  endtask

  task automatic read_sequence(input wdata_t a);
    send_req(FN_WRITE, REG_ADDR, a);
    send_req(FN_WRITE, REG_CTRL, CTL_RD | junk_bits());
    if (roll(30)) send_req(FN_READ, REG_ADDR, wdata_t'($urandom));
    send_req(FN_READ, REG_DATA, wdata_t'($urandom));
  endtask

  task automatic write_sequence(input bit poll, input bit must_start);
    wdata_t a;
    int     waits;
    a = pick_addr();
    send_req(FN_WRITE, REG_ADDR, a);
    send_req(FN_WRITE, REG_DATA, wdata_t'($urandom));
    send_req(FN_WRITE, REG_CTRL, CTL_MS | junk_bits());
    waits = must_start ? 0 : $urandom_range(ENABLE_WINDOW);
    repeat (waits) begin
      send_req(roll(60) ? FN_TICK : FN_READ, REG_CTRL, wdata_t'($urandom));
    end
    send_req(FN_WRITE, REG_CTRL, CTL_WR | junk_bits());
    if (poll) begin
      while (model_busy) begin
        send_req(roll(60) ? FN_TICK : FN_READ, sel_t'($urandom_range(2)),
                 wdata_t'($urandom));
      end
      read_sequence(a);
    end
  endtask

  task automatic random_burst(input int n, input bit writes_ok);
    int stop;
    int r;
    stop = sent + n;
    while (sent < stop) begin
      r = $urandom_range(99);
      if (r < 40 && writes_ok) begin
        write_sequence(1'b1, 1'b0);
      end else if (r < 70) begin
        read_sequence(pick_addr());
      end else begin
        send_req(func_t'($urandom_range(3)), sel_t'($urandom_range(3)), wdata_t'($urandom));
      end
    end
  endtask

  task automatic run_phase(input count_t wt, input idle_mode_e mode, input int n,
                           input bit long_hold);
    set_wtime(wt);
    idle_mode = mode;
    if (long_hold) hold_asks++;
    random_burst(n, 1'b1);
  endtask

  task automatic directed_checks();
    send_req(FN_READ,  REG_CTRL, '0);
    send_req(FN_READ,  REG_ADDR, '0);
    send_req(FN_READ,  REG_DATA, '0);
    set_wtime(16'd0);
    send_req(FN_WRITE, REG_ADDR, 16'hFFFF);
    send_req(FN_READ,  REG_ADDR, 16'hFFFF);
    send_req(FN_WRITE, REG_CTRL, CTL_RD);
    send_req(FN_READ,  REG_DATA, '0);
    send_req(FN_WRITE, REG_DATA, 16'hABCD);
    send_req(FN_WRITE, REG_CTRL, CTL_MS | CTL_WR);
    send_req(FN_READ,  REG_CTRL, '0);
    send_req(FN_WRITE, REG_CTRL, CTL_MS | CTL_WR);
    send_req(FN_READ,  REG_CTRL, 16'hFFFF);
    send_req(FN_WRITE, REG_ADDR, 16'h0000);
    send_req(FN_WRITE, REG_DATA, 16'h5500);
    send_req(FN_WRITE, REG_CTRL, CTL_RD);
    send_req(FN_WRITE, REG_CTRL, 16'hFF00);
    send_req(FN_WRITE, REG_CTRL, CTL_WR);
    send_req(FN_READ,  REG_ADDR, '0);
    send_req(FN_READ,  REG_DATA, '0);
    send_req(FN_NONE,  REG_CTRL, 16'hFFFF);
    send_req(FN_WRITE, REG_NONE, 16'hFFFF);
    send_req(FN_READ,  REG_NONE, 16'hFFFF);
    drain_busy();
    send_req(FN_WRITE, REG_DATA, 16'h0000);
    send_req(FN_WRITE, REG_CTRL, 16'hFFF9);
    send_req(FN_READ,  REG_DATA, '0);
    send_req(FN_READ,  REG_CTRL, '0);
  endtask

  initial begin : stimulus
    req_ch.valid   = 1'b0;
    req_ch.func    = FN_TICK;
    req_ch.reg_sel = REG_ADDR;
    req_ch.wdata   = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.data    = '0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    directed_checks();

    run_phase(16'd1, IDLE_NONE, 250, 1'b1);

    set_wtime(16'd120);
    idle_mode = IDLE_RECV;
    write_sequence(1'b0, 1'b1);
    random_burst(40, 1'b0);

    run_phase(16'd5, IDLE_SEND, 300, 1'b0);
    run_phase(count_t'($urandom_range(40, 2)), IDLE_RECV, 300, 1'b0);
    run_phase(16'd3, IDLE_BOTH, 300, 1'b0);
    run_phase(16'd1, IDLE_NONE, 150, 1'b1);
    run_phase(count_t'($urandom_range(64, 1)), IDLE_BOTH, 300, 1'b0);

    wait_drained();
    repeat (20) @(negedge clk);

    $display("Covered %0d requests (directed, write and read sequences, noise) over %0d write times",
             sent, settings + 1);
    $display("Checked %0d responses, %0d cell writes landed, %0d mismatches",
             checked, stores, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/eecr_pkg.sv
rtl/eecr_intf.sv
rtl/eecr_mem.sv
rtl/eecr_ctrl.sv
rtl/eeprom_controller_registers_top.sv
rtl/eecr_chk.sv
tb/eecr_checker.sv
tb/tb.sv
